/* hw/rtl/fsr_pkg.sv */
// ----------------------------------------------------------------------------
// fsr_pkg: shared types and constants for the fraction sum reducer
// Item structs, shared divider request and response, sequencer step codes.
// ----------------------------------------------------------------------------
`default_nettype none

package fsr_pkg;

    // Input field width; output widths follow from it
    localparam int IN_WIDTH  = 16;
    localparam int NUM_WIDTH = 2 * IN_WIDTH + 1;
    localparam int DEN_WIDTH = 2 * IN_WIDTH;
    // Datapath width of the shared divider, one bit of headroom over the numerator
    localparam int DW        = NUM_WIDTH + 1;

    typedef struct packed {
        logic [IN_WIDTH-1:0] first_numerator;
        logic [IN_WIDTH-1:0] first_denominator;
        logic [IN_WIDTH-1:0] second_numerator;
        logic [IN_WIDTH-1:0] second_denominator;
    } in_t;

    typedef struct packed {
        logic [NUM_WIDTH-1:0] sum_numerator;
        logic [DEN_WIDTH-1:0] sum_denominator;
        logic                 zero_denominator_error;
    } out_t;

    typedef struct packed {
        logic          start;
        logic [DW-1:0] dividend;
        logic [DW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic          done;
        logic [DW-1:0] quotient;
        logic [DW-1:0] remainder;
    } div_rsp_t;

    // Sequencer steps, in program order
    typedef enum logic [3:0] {
        STEP_G1 = 4'd0,   // gcd(n1, d1)
        STEP_N1 = 4'd1,   // n1 / g
        STEP_D1 = 4'd2,   // d1 / g
        STEP_G2 = 4'd3,   // gcd(n2, d2)
        STEP_N2 = 4'd4,   // n2 / g
        STEP_D2 = 4'd5,   // d2 / g
        STEP_G3 = 4'd6,   // gcd(d1, d2)
        STEP_T  = 4'd7,   // den = (d1 / g) * d2
        STEP_Q1 = 4'd8,   // num = n1 * (den / d1)
        STEP_Q2 = 4'd9,   // num += n2 * (den / d2)
        STEP_G4 = 4'd10,  // gcd(num, den)
        STEP_NF = 4'd11,  // num / g
        STEP_DF = 4'd12   // den / g
    } step_t;

endpackage

`default_nettype wire

/* hw/rtl/fraction_sum_reduce_top.sv */
// A zero denominator gives the result strobe in the cycle after acceptance.
// Throughput: one item at a time; busy stays high through the strobe cycle.
// The result is shown for one cycle with done high; the receiver cannot stall.
// Reset: rst_n asynchronous, active low; returns the sequencer to idle.
// ----------------------------------------------------------------------------
// fraction_sum_reduce_top: adds two fractions and reduces the sum
// Euclid GCDs, LCM and final reduction run on one shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

module fraction_sum_reduce_top
    import fsr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire in_t  operands,
    output logic      busy,
    output logic      done,
    output out_t      result
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SETUP  = 5'b00010,
        ST_GCDCHK = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_OUT    = 5'b10000
    } state_t;

    state_t                state_reg;
    step_t                 step_reg;
    logic [IN_WIDTH-1:0]   n1_reg, d1_reg, n2_reg, d2_reg;
    logic [DW-1:0]         p_reg, q_reg, g_reg;
    logic [DW-1:0]         num_reg;
    logic [DEN_WIDTH-1:0]  den_reg;
    logic                  err_reg;

    div_req_t              div_req;
    div_rsp_t              div_rsp;
    logic                  is_gcd;
    logic [DW-1:0]         div_a, div_b;
    logic [IN_WIDTH-1:0]   mul_a;
    logic [DEN_WIDTH-1:0]  prod;
    step_t                 step_next;

    fsr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign is_gcd = (step_reg == STEP_G1) || (step_reg == STEP_G2) ||
                    (step_reg == STEP_G3) || (step_reg == STEP_G4);

    // Division operands per step
    always_comb
    begin
        div_a = p_reg;
        div_b = q_reg;
        case (step_reg)
            STEP_N1: begin div_a = DW'(n1_reg);  div_b = g_reg;         end
            STEP_D1: begin div_a = DW'(d1_reg);  div_b = g_reg;         end
            STEP_N2: begin div_a = DW'(n2_reg);  div_b = g_reg;         end
            STEP_D2: begin div_a = DW'(d2_reg);  div_b = g_reg;         end
            STEP_T:  begin div_a = DW'(d1_reg);  div_b = g_reg;         end
            STEP_Q1: begin div_a = DW'(den_reg); div_b = DW'(d1_reg);   end
            STEP_Q2: begin div_a = DW'(den_reg); div_b = DW'(d2_reg);   end
            STEP_NF: begin div_a = num_reg;      div_b = g_reg;         end
            STEP_DF: begin div_a = DW'(den_reg); div_b = g_reg;         end
            default: begin div_a = p_reg;        div_b = q_reg;         end
        endcase
    end

    assign div_req.start    = ((state_reg == ST_SETUP) && !is_gcd) ||
                              ((state_reg == ST_GCDCHK) && (q_reg != '0));
    assign div_req.dividend = div_a;
    assign div_req.divisor  = div_b;

    // Multiplier fed by the registered quotient
    always_comb
    begin
        case (step_reg)
            STEP_T:  mul_a = d2_reg;
            STEP_Q1: mul_a = n1_reg;
            default: mul_a = n2_reg;
        endcase
    end
    assign prod = DEN_WIDTH'(mul_a) * DEN_WIDTH'(div_rsp.quotient[IN_WIDTH-1:0]);

    // Program order
    always_comb
    begin
        case (step_reg)
            STEP_G1: step_next = STEP_N1;
            STEP_N1: step_next = STEP_D1;
            STEP_D1: step_next = STEP_G2;
            STEP_G2: step_next = STEP_N2;
            STEP_N2: step_next = STEP_D2;
            STEP_D2: step_next = STEP_G3;
            STEP_G3: step_next = STEP_T;
            STEP_T:  step_next = STEP_Q1;
            STEP_Q1: step_next = STEP_Q2;
            STEP_Q2: step_next = STEP_G4;
            STEP_G4: step_next = STEP_NF;
            STEP_NF: step_next = STEP_DF;
            default: step_next = STEP_G1;
        endcase
    end

    // Sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_G1;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        step_reg <= STEP_G1;
                        if (operands.first_denominator == '0 ||
                            operands.second_denominator == '0)
                            state_reg <= ST_OUT;
                        else
                            state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP:
                begin
                    state_reg <= is_gcd ? ST_GCDCHK : ST_DIV;
                end
                ST_GCDCHK:
                begin
                    if (q_reg == '0)
                    begin
                        step_reg  <= step_next;
                        state_reg <= ST_SETUP;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        if (is_gcd)
                            state_reg <= ST_GCDCHK;
                        else if (step_reg == STEP_DF)
                            state_reg <= ST_OUT;
                        else
                        begin
                            step_reg  <= step_next;
                            state_reg <= ST_SETUP;
                        end
                    end
                end
                ST_OUT:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    n1_reg  <= operands.first_numerator;
                    d1_reg  <= operands.first_denominator;
                    n2_reg  <= operands.second_numerator;
                    d2_reg  <= operands.second_denominator;
                    err_reg <= (operands.first_denominator == '0) ||
                               (operands.second_denominator == '0);
                    num_reg <= '0;
                    den_reg <= '0;
                end
            end
            ST_SETUP:
            begin
                // Load Euclid operands
                case (step_reg)
                    STEP_G1: begin p_reg <= DW'(n1_reg);  q_reg <= DW'(d1_reg);  end
                    STEP_G2: begin p_reg <= DW'(n2_reg);  q_reg <= DW'(d2_reg);  end
                    STEP_G3: begin p_reg <= DW'(d1_reg);  q_reg <= DW'(d2_reg);  end
                    STEP_G4: begin p_reg <= num_reg;      q_reg <= DW'(den_reg); end
                    default: ;
                endcase
            end
            ST_GCDCHK:
            begin
                if (q_reg == '0)
                    g_reg <= p_reg;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    case (step_reg)
                        STEP_G1, STEP_G2, STEP_G3, STEP_G4:
                        begin
                            p_reg <= q_reg;
                            q_reg <= div_rsp.remainder;
                        end
                        STEP_N1: n1_reg  <= div_rsp.quotient[IN_WIDTH-1:0];
                        STEP_D1: d1_reg  <= div_rsp.quotient[IN_WIDTH-1:0];
                        STEP_N2: n2_reg  <= div_rsp.quotient[IN_WIDTH-1:0];
                        STEP_D2: d2_reg  <= div_rsp.quotient[IN_WIDTH-1:0];
                        STEP_T:  den_reg <= prod;
                        STEP_Q1: num_reg <= DW'(prod);
                        STEP_Q2: num_reg <= num_reg + DW'(prod);
                        STEP_NF: num_reg <= div_rsp.quotient;
                        STEP_DF: den_reg <= div_rsp.quotient[DEN_WIDTH-1:0];
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // Ports
    assign busy                          = (state_reg != ST_IDLE);
    assign done                          = (state_reg == ST_OUT);
    assign result.sum_numerator          = num_reg[NUM_WIDTH-1:0];
    assign result.sum_denominator        = den_reg;
    assign result.zero_denominator_error = err_reg;

    // Checks
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("item accepted but not busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe longer than one cycle");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.zero_denominator_error |->
        (result.sum_numerator == '0) && (result.sum_denominator == '0))
        else $error("error result not zero");
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.zero_denominator_error |-> (result.sum_denominator != '0))
        else $error("zero denominator without error");

endmodule

`default_nettype wire

/* hw/rtl/fsr_div.sv */
// ----------------------------------------------------------------------------
// fsr_div: shared restoring divider
// One quotient bit per cycle; quotient and remainder valid when done pulses.
// ----------------------------------------------------------------------------
`default_nettype none

module fsr_div
    import fsr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    quo_reg;
    logic [DW-1:0]    rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DW:0]      trial;
    logic             fits;

    // Partial remainder with next dividend bit shifted in
    assign trial = {rem_reg, quo_reg[DW-1]};
    assign fits  = (trial >= {1'b0, req.divisor});

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DW);
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath; divisor is held steady by the sequencer while running
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            if (fits)
                rem_reg <= DW'(trial - {1'b0, req.divisor});
            else
                rem_reg <= trial[DW-1:0];
            quo_reg <= {quo_reg[DW-2:0], fits};
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

    // Checks
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("divider done longer than one cycle");
    a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
        !(run_reg && done_reg)) else $error("divider done while running");
    a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> run_reg) else $error("divider did not start");

endmodule

`default_nettype wire

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the fraction sum reducer
// Directed and random fraction pairs, burst-gapped start, per-field checks.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module testbench;
    import fsr_pkg::*;

    logic clk;
    logic rst_n;
    logic start = 1'b0;
    in_t  operands = '0;
    logic busy;
    logic done;
    out_t result;

    in_t  pending_items[$];
    out_t expected_sums[$];
    int   mismatch_count = 0;
    bit   stim_done = 1'b0;
    int   gap_left = 0;
    int   burst_left = 0;

    fraction_sum_reduce_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .operands (operands),
        .busy     (busy),
        .done     (done),
        .result   (result)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic longint unsigned gcd_of(longint unsigned p, longint unsigned q);
        longint unsigned r;
        while (q != 0)
        begin
            r = p % q;
            p = q;
            q = r;
        end
        return p;
    endfunction

    // Expected reduced sum of one fraction pair
    function automatic out_t fraction_sum(in_t it);
        out_t o;
        longint unsigned n1, d1, n2, d2, g, den, num;
        n1 = 64'(it.first_numerator);
        d1 = 64'(it.first_denominator);
        n2 = 64'(it.second_numerator);
        d2 = 64'(it.second_denominator);
        o = '0;
        if (d1 == 0 || d2 == 0)
        begin
            o.zero_denominator_error = 1'b1;
            return o;
        end
        g = gcd_of(n1, d1);
        n1 = n1 / g;
        d1 = d1 / g;
        g = gcd_of(n2, d2);
        n2 = n2 / g;
        d2 = d2 / g;
        g = gcd_of(d1, d2);
        den = (d1 / g) * d2;
        num = n1 * (den / d1) + n2 * (den / d2);
        g = gcd_of(num, den);
        if (g != 0)
        begin
            num = num / g;
            den = den / g;
        end
        o.sum_numerator   = num[NUM_WIDTH-1:0];
        o.sum_denominator = den[DEN_WIDTH-1:0];
        return o;
    endfunction

    function automatic logic [IN_WIDTH-1:0] rand_field();
        logic [IN_WIDTH-1:0] v;
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = '1;
            2: v = IN_WIDTH'($urandom_range(1, 16));
            3: v = IN_WIDTH'($urandom_range(1, 255));
            default: v = IN_WIDTH'($urandom);
        endcase
        return v;
    endfunction

    task automatic add_item(int n1, int d1, int n2, int d2);
        in_t it;
        it.first_numerator    = IN_WIDTH'(n1);
        it.first_denominator  = IN_WIDTH'(d1);
        it.second_numerator   = IN_WIDTH'(n2);
        it.second_denominator = IN_WIDTH'(d2);
        pending_items.push_back(it);
    endtask

    // Stimulus
    initial
    begin
        in_t it;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        add_item(1, 2, 1, 3);
        add_item(1, 2, 1, 2);
        add_item(0, 5, 0, 7);       // zero sum gives 0/1
        add_item(0, 5, 3, 9);       // one zero numerator
        add_item(4, 6, 0, 1);
        add_item(3, 0, 1, 2);       // zero first denominator
        add_item(3, 4, 1, 0);       // zero second denominator
        add_item(0, 0, 0, 0);
        add_item(65535, 65535, 65535, 65535);
        add_item(65535, 1, 65535, 1);   // largest numerator
        add_item(1, 65535, 1, 65534);   // largest denominator
        add_item(65535, 65534, 65534, 65533);
        add_item(1, 1, 1, 1);
        add_item(6, 4, 10, 15);
        add_item(32768, 3, 21845, 7);
        add_item(12345, 54321, 43210, 1234);
        repeat (1050)
        begin
            it.first_numerator    = rand_field();
            it.first_denominator  = rand_field();
            it.second_numerator   = rand_field();
            it.second_denominator = rand_field();
            pending_items.push_back(it);
        end
        stim_done = 1'b1;
    end

    // Driver: bursts of items with random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_sums.push_back(fraction_sum(operands));
            end
            if (start && busy)
            begin
                // hold the item until accepted
            end
            else if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_items.size() > 0)
            begin
                start <= 1'b1;
                operands <= pending_items.pop_front();
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 8);
                    if ($urandom_range(0, 2) != 0)
                        gap_left <= $urandom_range(0, 40);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: check each result against the oldest expectation
    always @(posedge clk)
    begin
        out_t exp_sum;
        if (rst_n && done)
        begin
            if (expected_sums.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                    $display("unexpected result %h", result);
            end
            else
            begin
                exp_sum = expected_sums.pop_front();
                if (result.sum_numerator !== exp_sum.sum_numerator ||
                    result.sum_denominator !== exp_sum.sum_denominator ||
                    result.zero_denominator_error !== exp_sum.zero_denominator_error)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %0d/%0d err %0b, got %0d/%0d err %0b",
                            exp_sum.sum_numerator, exp_sum.sum_denominator,
                            exp_sum.zero_denominator_error, result.sum_numerator,
                            result.sum_denominator, result.zero_denominator_error);
                end
            end
        end
    end

    // End of run
    initial
    begin
        wait (stim_done);
        wait (pending_items.size() == 0 && !start);
        wait (expected_sums.size() == 0);
        repeat (2000) @(posedge clk);
        if (mismatch_count == 0 && expected_sums.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #500ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
